FILE: rtl/core/jti_pkg.sv
// ----------------------------------------------------------------------------
// jti_pkg: shared types and constants for the joint trajectory interpolator
// Field widths, command codes, controller states and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package jti_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int JOINTS_DEF     = 6;

  localparam int NS_W    = 40;   // time fields, ns
  localparam int POS_W   = 20;   // Q3.16 positions and velocities
  localparam int SCALE_W = 10;   // Q2.8 speed scale
  localparam int MODE_W  = 3;
  localparam int JOINT_W = 3;
  localparam int IN_POS  = 6;    // joints carried by the load word

  localparam int NUM_W = 62;     // divider dividend
  localparam int Q_W   = 22;     // divider quotient bits
  localparam int CNT_W = 5;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [Q_W-1:0] VMAX_MAG = Q_W'(524287);
  localparam logic [Q_W-1:0] VMIN_MAG = Q_W'(524288);
  localparam logic signed [POS_W-1:0] VEL_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] VEL_MIN = 20'sh80000;
  localparam logic [NS_W-1:0] NS_MAX = {NS_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 3'd0,
    MODE_TICK   = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_PAUSE  = 3'd3,
    MODE_RESUME = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_HOLD,
    SEL_INTERP
  } sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADV,
    ST_FIRST,
    ST_LASTT,
    ST_SCAN,
    ST_SPAN,
    ST_CAP,
    ST_JRDL,
    ST_JRDR,
    ST_JD,
    ST_JM1,
    ST_JM2,
    ST_JM3,
    ST_PNUM,
    ST_PDIV,
    ST_VNUM,
    ST_VDIV,
    ST_EMIT,
    ST_HRD,
    ST_HDAT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/joint_trajectory_interpolator.sv
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator: timed waypoint table with linear interpolation
// Stores waypoints in two synchronous memories; each tick advances the
// trajectory clock, scans for the bracketing segment and emits one word per
// joint with position, segment velocity and finished flag.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | start / busy          | in_mode, in_now_ns, in_point_time_ns,
//          |                       | in_first_point, in_pos_a .. in_pos_f
//  out     | out_valid (strobe)    | out_joint, out_position, out_velocity,
//          |                       | out_finished, out_last
//  cfg     | cfg_valid / cfg_ready | cfg_data (speed scale, Q2.8)
//
// A load makes one position memory write per joint, unless paused or the
// table is full. In a tick the table scan reads one time per cycle, and
// each interpolated joint runs the shared one-bit-per-cycle divider twice
// (22 steps each). Results leave one per strobe, the receiver cannot stall.
// Reset is synchronous; the waypoint memories are not cleared, entries at or
// above the point count are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_trajectory_interpolator
  import jti_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int JOINTS     = JOINTS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [MODE_W-1:0]       in_mode,
  input  wire logic [NS_W-1:0]         in_now_ns,
  input  wire logic [NS_W-1:0]         in_point_time_ns,
  input  wire logic                    in_first_point,
  input  wire logic signed [POS_W-1:0] in_pos_a,
  input  wire logic signed [POS_W-1:0] in_pos_b,
  input  wire logic signed [POS_W-1:0] in_pos_c,
  input  wire logic signed [POS_W-1:0] in_pos_d,
  input  wire logic signed [POS_W-1:0] in_pos_e,
  input  wire logic signed [POS_W-1:0] in_pos_f,
  output      logic                    out_valid,
  output      logic [JOINT_W-1:0]      out_joint,
  output      logic signed [POS_W-1:0] out_position,
  output      logic signed [POS_W-1:0] out_velocity,
  output      logic                    out_finished,
  output      logic                    out_last,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [SCALE_W-1:0]      cfg_data
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int PD   = MAX_POINTS * JOINTS;
  localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int JCW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [CW-1:0]  MAXC  = CW'(MAX_POINTS);
  localparam logic [JCW-1:0] JLAST = JCW'(JOINTS - 1);

  // memories
  logic [NS_W-1:0]         tmem [MAX_POINTS];
  logic signed [POS_W-1:0] pmem [PD];
  logic [NS_W-1:0]         t_rd_r;
  logic signed [POS_W-1:0] p_rd_r;
  logic                    t_we, p_we;
  logic [AW-1:0]           t_raddr, t_waddr;
  logic [PAW-1:0]          p_raddr, p_waddr;
  logic signed [POS_W-1:0] p_wdata;

  state_t state_r, state_nxt;
  sel_t   sel_r;

  logic [SCALE_W-1:0]      speed_r;
  logic [CW-1:0]           count_r;
  logic [NS_W-1:0]         clock_r, prev_now_r;
  logic                    have_prev_r, skip_r, active_r, paused_r, have_held_r;
  logic signed [POS_W-1:0] held_r [JOINTS];
  logic [NS_W-1:0]         ld_time_r;
  logic signed [POS_W-1:0] ld_pos_r [IN_POS];

  logic [NS_W-1:0]         delta_r;
  logic [NS_W+SCALE_W-1:0] prod_r;
  logic [NS_W-1:0]         t0_r, prev_t_r, tl_r, tr_r, span_r, off_r;
  logic [AW-1:0]           i_r;
  logic [PAW-1:0]          base_r;
  logic [JCW-1:0]          j_r;
  logic                    fin_r;
  logic signed [POS_W-1:0] l_r, pos_r;
  logic                    neg_r;
  logic [POS_W:0]          magd_r;
  logic [POS_W+20:0]       plo_r, phi_r;
  logic [POS_W+30:0]       vprod_r;

  // shared divider
  logic [NUM_W-1:0] rem_r, dsh_r;
  logic [Q_W-1:0]   q_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic             div_ge;

  logic              accept;
  logic [AW-1:0]     lastp;
  logic [PAW-1:0]    cnt_base;
  logic [NUM_W-1:0]  pnum, vnum;
  logic [NS_W+2:0]   clk_sum;
  logic signed [POS_W:0]   d_full;
  logic signed [Q_W:0]     q_s, pos_full;
  logic signed [POS_W-1:0] vel_sat, out_pos;
  logic signed [POS_W-1:0] ld_sel;
  logic [2:0]              ld_idx;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign lastp    = AW'(count_r - 1'b1);
  assign cnt_base = PAW'(count_r * JOINTS);
  assign clk_sum  = {3'b000, clock_r} + {1'b0, prod_r[NS_W+SCALE_W-1:8]};
  assign pnum     = NUM_W'({phi_r, 20'd0}) + NUM_W'(plo_r) + NUM_W'(span_r >> 1);
  assign vnum     = NUM_W'(vprod_r) + NUM_W'(span_r >> 1);
  assign div_ge   = (rem_r >= dsh_r);
  assign d_full   = {p_rd_r[POS_W-1], p_rd_r} - {l_r[POS_W-1], l_r};
  assign q_s      = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign pos_full = {{(Q_W-POS_W+1){l_r[POS_W-1]}}, l_r} + q_s;
  assign ld_idx   = 3'(j_r);
  assign ld_sel   = (32'(j_r) < IN_POS) ? ld_pos_r[ld_idx] : '0;

  always_comb begin
    if (!neg_r) begin
      vel_sat = (ovf_r || q_r > VMAX_MAG) ? VEL_MAX : POS_W'(q_r);
    end else begin
      vel_sat = (ovf_r || q_r > VMIN_MAG) ? VEL_MIN : POS_W'(-$signed({1'b0, q_r}));
    end
  end

  assign out_pos = (paused_r && have_held_r) ? held_r[j_r] : pos_r;

  // memory ports
  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= ld_time_r;
    end
    t_rd_r <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rd_r <= pmem[p_raddr];
  end

  // next state and memory control
  always_comb begin
    state_nxt = state_r;
    t_raddr   = '0;
    t_we      = 1'b0;
    t_waddr   = AW'(count_r);
    p_we      = 1'b0;
    p_waddr   = cnt_base + PAW'(j_r);
    p_wdata   = ld_sel;
    p_raddr   = base_r + PAW'(j_r);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD: if (!paused_r) state_nxt = ST_LOAD;
            MODE_TICK: state_nxt = ST_MUL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (count_r >= MAXC) begin
          state_nxt = ST_IDLE;
        end else begin
          t_we = (j_r == '0);
          p_we = 1'b1;
          if (j_r == JLAST) state_nxt = ST_IDLE;
        end
      end
      ST_MUL: state_nxt = ST_ADV;
      ST_ADV: state_nxt = (count_r == '0) ? ST_EMIT : ST_FIRST;
      ST_FIRST: begin
        t_raddr = lastp;
        state_nxt = (clock_r <= t_rd_r) ? ST_HRD : ST_LASTT;
      end
      ST_LASTT: begin
        t_raddr = AW'(1);
        state_nxt = (clock_r >= t_rd_r) ? ST_HRD : ST_SCAN;
      end
      ST_SCAN: begin
        t_raddr = i_r + 1'b1;
        if (clock_r <= t_rd_r) state_nxt = ST_SPAN;
      end
      ST_SPAN: state_nxt = ST_CAP;
      ST_CAP:  state_nxt = ST_JRDL;
      ST_JRDL: state_nxt = ST_JRDR;
      ST_JRDR: begin
        p_raddr   = base_r + PAW'(JOINTS) + PAW'(j_r);
        state_nxt = ST_JD;
      end
      ST_JD:   state_nxt = ST_JM1;
      ST_JM1:  state_nxt = ST_JM2;
      ST_JM2:  state_nxt = ST_JM3;
      ST_JM3:  state_nxt = ST_PNUM;
      ST_PNUM: state_nxt = ST_PDIV;
      ST_PDIV: if (cnt_r == '0) state_nxt = ST_VNUM;
      ST_VNUM: state_nxt = ST_VDIV;
      ST_VDIV: if (cnt_r == '0) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (j_r == JLAST) begin
          state_nxt = ST_IDLE;
        end else begin
          case (sel_r)
            SEL_HOLD:   state_nxt = ST_HRD;
            SEL_INTERP: state_nxt = ST_JRDL;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_HRD:  state_nxt = ST_HDAT;
      ST_HDAT: state_nxt = ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SCALE_RST;
      count_r     <= '0;
      clock_r     <= '0;
      prev_now_r  <= '0;
      have_prev_r <= 1'b0;
      skip_r      <= 1'b0;
      active_r    <= 1'b0;
      paused_r    <= 1'b0;
      have_held_r <= 1'b0;
      out_valid   <= 1'b0;
      for (int k = 0; k < JOINTS; k++) held_r[k] <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) speed_r <= cfg_data;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_LOAD: begin
                if (!paused_r && in_first_point) begin
                  count_r  <= '0;
                  clock_r  <= '0;
                  active_r <= 1'b1;
                end
              end
              MODE_TICK: begin
                skip_r      <= 1'b0;
                prev_now_r  <= in_now_ns;
                have_prev_r <= 1'b1;
              end
              MODE_STOP: begin
                active_r <= 1'b0;
                paused_r <= 1'b0;
                count_r  <= '0;
              end
              MODE_PAUSE: paused_r <= 1'b1;
              MODE_RESUME: begin
                if (paused_r) begin
                  paused_r <= 1'b0;
                  skip_r   <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          if (count_r < MAXC && j_r == JLAST) count_r <= count_r + 1'b1;
        end
        ST_ADV: begin
          if (active_r && !paused_r) begin
            clock_r <= (clk_sum > {3'b000, NS_MAX}) ? NS_MAX : clk_sum[NS_W-1:0];
          end
        end
        ST_LASTT: if (clock_r >= t_rd_r) active_r <= 1'b0;
        ST_EMIT: begin
          out_valid      <= 1'b1;
          held_r[j_r]    <= out_pos;
          if (j_r == JLAST) have_held_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        j_r       <= '0;
        ld_time_r <= in_point_time_ns;
        ld_pos_r[0] <= in_pos_a;
        ld_pos_r[1] <= in_pos_b;
        ld_pos_r[2] <= in_pos_c;
        ld_pos_r[3] <= in_pos_d;
        ld_pos_r[4] <= in_pos_e;
        ld_pos_r[5] <= in_pos_f;
        // no advance on the first tick, after a resume, or if time ran back
        if (!have_prev_r || skip_r || in_now_ns < prev_now_r) begin
          delta_r <= '0;
        end else begin
          delta_r <= in_now_ns - prev_now_r;
        end
      end
      ST_LOAD: j_r <= j_r + 1'b1;
      ST_MUL:  prod_r <= delta_r * speed_r;
      ST_ADV: begin
        j_r   <= '0;
        sel_r <= SEL_ZERO;
        fin_r <= 1'b0;
        pos_r <= '0;
      end
      ST_FIRST: begin
        t0_r   <= t_rd_r;
        sel_r  <= SEL_HOLD;
        base_r <= '0;
      end
      ST_LASTT: begin
        base_r   <= PAW'(lastp * JOINTS);
        fin_r    <= (clock_r >= t_rd_r);
        prev_t_r <= t0_r;
        i_r      <= AW'(1);
      end
      ST_SCAN: begin
        if (clock_r <= t_rd_r) begin
          tl_r   <= prev_t_r;
          tr_r   <= t_rd_r;
          base_r <= PAW'((i_r - 1'b1) * JOINTS);
          sel_r  <= SEL_INTERP;
        end else begin
          prev_t_r <= t_rd_r;
          i_r      <= i_r + 1'b1;
        end
      end
      ST_SPAN: begin
        span_r <= (tr_r > tl_r) ? tr_r - tl_r : NS_W'(1);
        off_r  <= (clock_r > tl_r) ? clock_r - tl_r : '0;
      end
      ST_CAP:  if (off_r > span_r) off_r <= span_r;
      ST_JRDR: l_r <= p_rd_r;
      ST_JD: begin
        neg_r  <= d_full[POS_W];
        magd_r <= d_full[POS_W] ? $unsigned(-d_full) : $unsigned(d_full);
      end
      ST_JM1: plo_r <= magd_r * off_r[19:0];
      ST_JM2: phi_r <= magd_r * off_r[NS_W-1:20];
      ST_JM3: vprod_r <= magd_r * NS_PER_S;
      ST_PNUM: begin
        rem_r <= pnum;
        dsh_r <= NUM_W'({span_r, 21'd0});
        ovf_r <= (pnum >= NUM_W'({span_r, 22'd0}));
        q_r   <= '0;
        cnt_r <= CNT_W'(Q_W - 1);
      end
      ST_PDIV, ST_VDIV: begin
        if (div_ge) rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[Q_W-2:0], div_ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      ST_VNUM: begin
        pos_r <= pos_full[POS_W-1:0];
        rem_r <= vnum;
        dsh_r <= NUM_W'({span_r, 21'd0});
        ovf_r <= (vnum >= NUM_W'({span_r, 22'd0}));
        q_r   <= '0;
        cnt_r <= CNT_W'(Q_W - 1);
      end
      ST_EMIT: begin
        out_joint    <= JOINT_W'(j_r);
        out_position <= out_pos;
        out_velocity <= (sel_r == SEL_INTERP && !paused_r) ? vel_sat : '0;
        out_finished <= fin_r;
        out_last     <= (j_r == JLAST);
        j_r          <= j_r + 1'b1;
      end
      ST_HDAT: pos_r <= p_rd_r;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/joint_trajectory_interpolator_test.sv
// ----------------------------------------------------------------------------
// joint_trajectory_interpolator_test: self-checking bench for the interpolator
// Walks a directed command table, then random trajectories and noise, under
// several speed scales. A behavioral predictor queues the expected word per
// joint; a monitor compares every strobed result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_trajectory_interpolator_test;
  import jti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int NJ = JOINTS_DEF;
  localparam longint unsigned T_MASK = 64'hFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT = 20;
  localparam int ITEMS_TARGET = 170;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam longint signed P_MAX = 524287;
  localparam longint signed P_MIN = -524288;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [NS_W-1:0] now;
    logic [NS_W-1:0] pt;
    logic fp;
    logic [NJ-1:0][POS_W-1:0] pos;
  } cmd_t;

  typedef struct {
    logic [JOINT_W-1:0] joint;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic fin;
    logic last;
  } word_t;

  typedef struct {
    cmd_t c;
    bit chk;
    logic signed [POS_W-1:0] epos;
    logic signed [POS_W-1:0] evel;
    logic efin;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [NS_W-1:0] in_now_ns = '0;
  logic [NS_W-1:0] in_point_time_ns = '0;
  logic in_first_point = 0;
  logic signed [POS_W-1:0] in_pos_a = '0, in_pos_b = '0, in_pos_c = '0;
  logic signed [POS_W-1:0] in_pos_d = '0, in_pos_e = '0, in_pos_f = '0;
  logic out_valid;
  logic [JOINT_W-1:0] out_joint;
  logic signed [POS_W-1:0] out_position, out_velocity;
  logic out_finished, out_last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;

  joint_trajectory_interpolator uut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_now_ns, .in_point_time_ns,
    .in_first_point, .in_pos_a, .in_pos_b, .in_pos_c, .in_pos_d, .in_pos_e,
    .in_pos_f, .out_valid, .out_joint, .out_position, .out_velocity,
    .out_finished, .out_last, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint unsigned wp_time[NPTS];
  longint signed wp_pos[NPTS][NJ];
  int wp_count;
  longint unsigned traj_clk, prev_now;
  bit have_prev, skip_delta, active, paused, have_held;
  longint signed held_pos[NJ];
  longint unsigned scale;

  word_t pending_q[$];
  int errors = 0, checked = 0, ticks = 0, loads = 0, cfg_writes = 0;
  int items = 0;
  int cycles = 0;
  bit no_idle = 0;

  function automatic longint signed round_div(longint signed num, longint unsigned den);
    longint unsigned mag, q;
    mag = num < 0 ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint signed clamp20(longint signed v);
    return v > P_MAX ? P_MAX : (v < P_MIN ? P_MIN : v);
  endfunction

  task automatic predict_tick(input logic [NS_W-1:0] now_in);
    longint unsigned now, delta, tl, tr, span, off;
    longint signed l, d;
    longint signed pos[NJ], vel[NJ];
    bit fin;
    word_t w;
    int lastp;
    now = 64'(now_in);
    fin = 0;
    delta = (!have_prev || skip_delta || now < prev_now) ? 64'd0 : now - prev_now;
    skip_delta = 0;
    prev_now = now;
    have_prev = 1;
    if (active && !paused) begin
      traj_clk += (delta * scale) >> 8;
      if (traj_clk > T_MASK) traj_clk = T_MASK;
    end
    foreach (pos[j]) begin
      pos[j] = 0;
      vel[j] = 0;
    end
    if (wp_count > 0) begin
      lastp = wp_count - 1;
      if (traj_clk <= wp_time[0]) begin
        foreach (pos[j]) pos[j] = wp_pos[0][j];
      end else if (traj_clk >= wp_time[lastp]) begin
        foreach (pos[j]) pos[j] = wp_pos[lastp][j];
        active = 0;
        fin = 1;
      end else begin
        for (int i = 1; i < wp_count; i++) begin
          if (traj_clk > wp_time[i]) continue;
          tl = wp_time[i-1];
          tr = wp_time[i];
          span = tr > tl ? tr - tl : 64'd1;
          off = traj_clk > tl ? traj_clk - tl : 64'd0;
          if (off > span) off = span;
          foreach (pos[j]) begin
            l = wp_pos[i-1][j];
            d = wp_pos[i][j] - l;
            pos[j] = clamp20(l + round_div(d * longint'(off), span));
            vel[j] = clamp20(round_div(d * 64'sd1000000000, span));
          end
          break;
        end
      end
    end
    if (paused) begin
      foreach (pos[j]) begin
        if (have_held) pos[j] = held_pos[j];
        vel[j] = 0;
      end
    end
    foreach (pos[j]) held_pos[j] = pos[j];
    have_held = 1;
    for (int j = 0; j < NJ; j++) begin
      w.joint = JOINT_W'(j);
      w.pos = POS_W'(pos[j]);
      w.vel = POS_W'(vel[j]);
      w.fin = fin;
      w.last = (j == NJ - 1);
      pending_q.insert(pending_q.size(), w);
    end
  endtask

  task automatic predict_cmd(input cmd_t c);
    case (c.mode)
      MODE_LOAD: if (!paused) begin
        loads++;
        if (c.fp) begin
          wp_count = 0;
          traj_clk = 0;
          active = 1;
        end
        if (wp_count < NPTS) begin
          wp_time[wp_count] = 64'(c.pt);
          for (int j = 0; j < NJ; j++) wp_pos[wp_count][j] = $signed(c.pos[j]);
          wp_count++;
        end
      end
      MODE_TICK: begin
        ticks++;
        predict_tick(c.now);
      end
      MODE_STOP: begin
        active = 0;
        paused = 0;
        wp_count = 0;
      end
      MODE_PAUSE: paused = 1;
      MODE_RESUME: if (paused) begin
        paused = 0;
        skip_delta = 1;
      end
      default: ;
    endcase
  endtask

  // one command word: random gap, then hold start until accepted
  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_mode <= c.mode;
    in_now_ns <= c.now;
    in_point_time_ns <= c.pt;
    in_first_point <= c.fp;
    in_pos_a <= c.pos[0];
    in_pos_b <= c.pos[1];
    in_pos_c <= c.pos[2];
    in_pos_d <= c.pos[3];
    in_pos_e <= c.pos[4];
    in_pos_f <= c.pos[5];
    do @(posedge clk); while (busy);
    items++;
    predict_cmd(c);
  endtask

  task automatic drain();
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    scale = 64'(v);
    cfg_writes++;
  endtask

  function automatic cmd_t mk(logic [MODE_W-1:0] m, longint unsigned now,
                              longint unsigned pt, logic fp, longint signed p);
    cmd_t c;
    c.mode = m;
    c.now = NS_W'(now);
    c.pt = NS_W'(pt);
    c.fp = fp;
    for (int j = 0; j < NJ; j++) c.pos[j] = POS_W'(p);
    return c;
  endfunction

  function automatic cmd_t rand_cmd(logic [MODE_W-1:0] m);
    cmd_t c;
    c.mode = m;
    c.now = NS_W'({$urandom, $urandom});
    c.pt = NS_W'({$urandom, $urandom});
    c.fp = 1'($urandom_range(0, 1));
    for (int j = 0; j < NJ; j++) c.pos[j] = POS_W'($urandom);
    return c;
  endfunction

  function automatic row_t plain(cmd_t c);
    row_t r;
    r.c = c;
    r.chk = 0;
    r.epos = 0;
    r.evel = 0;
    r.efin = 0;
    return r;
  endfunction

  function automatic row_t typed(cmd_t c, longint signed p, longint signed v, logic f);
    row_t r;
    r = plain(c);
    r.chk = 1;
    r.epos = POS_W'(p);
    r.evel = POS_W'(v);
    r.efin = f;
    return r;
  endfunction

  // random trajectory with interior ticks, sometimes paused mid-way
  task automatic run_trajectory(input int npts);
    cmd_t c;
    longint unsigned t, now;
    int nticks, shift;
    shift = $urandom_range(4, 24);
    t = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1 << shift);
    for (int k = 0; k < npts; k++) begin
      c = rand_cmd(MODE_LOAD);
      c.fp = (k == 0);
      c.pt = NS_W'(t);
      if ($urandom_range(0, 15) == 0) c.pt = NS_W'({$urandom, $urandom});
      send_cmd(c);
      t += $urandom_range(1, 1 << shift);
    end
    now = {$urandom_range(0, 255), $urandom};
    nticks = $urandom_range(3, 8);
    for (int k = 0; k < nticks; k++) begin
      c = rand_cmd(MODE_TICK);
      c.now = NS_W'(now);
      send_cmd(c);
      now += $urandom_range(0, 32'((t / (nticks > 0 ? nticks : 1)) + 1));
      if ($urandom_range(0, 9) == 0) send_cmd(mk(MODE_PAUSE, 0, 0, 0, 0));
      if ($urandom_range(0, 9) == 0) send_cmd(mk(MODE_RESUME, 0, 0, 0, 0));
    end
  endtask

  always @(posedge clk) begin
    word_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word joint=%0d pos=%0d vel=%0d",
                 $realtime, out_joint, out_position, out_velocity);
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (out_joint !== e.joint || out_position !== e.pos || out_velocity !== e.vel ||
            out_finished !== e.fin || out_last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp j=%0d p=%0d v=%0d f=%0b l=%0b got j=%0d p=%0d v=%0d f=%0b l=%0b",
                   $realtime, e.joint, e.pos, e.vel, e.fin, e.last, out_joint,
                   out_position, out_velocity, out_finished, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    cmd_t c;
    int n, base;
    logic [SCALE_W-1:0] scales[5];

    scales = '{10'd26, 10'd512, 10'd0, 10'd1023, 10'd256};
    scale = 64'(SCALE_RST);
    wp_count = 0;
    traj_clk = 0;
    prev_now = 0;
    {have_prev, skip_delta, active, paused, have_held} = '0;
    foreach (held_pos[j]) held_pos[j] = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_scale(SCALE_RST);

    tbl.insert(tbl.size(), typed(mk(MODE_TICK, 0, 0, 0, 0), 0, 0, 0));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 0, 1, P_MAX)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 1000, 0, P_MIN)));
    tbl.insert(tbl.size(), typed(mk(MODE_TICK, 0, 0, 0, 0), P_MAX, 0, 0));
    tbl.insert(tbl.size(), plain(mk(MODE_TICK, 100, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_TICK, 999, 0, 0, 0)));
    tbl.insert(tbl.size(), typed(mk(MODE_TICK, 2000, 0, 0, 0), P_MIN, 0, 1));
    tbl.insert(tbl.size(), plain(mk(MODE_PAUSE, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 5, 1, 7)));
    tbl.insert(tbl.size(), typed(mk(MODE_TICK, 3000, 0, 0, 0), P_MIN, 0, 1));
    tbl.insert(tbl.size(), plain(mk(MODE_RESUME, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_RESUME, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_STOP, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), typed(mk(MODE_TICK, T_MASK, 0, 0, 0), 0, 0, 0));
    tbl.insert(tbl.size(), plain(mk(MODE_UNUSED_LO, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_UNUSED_HI, 0, 0, 0, 0)));
    // backward time, then identical times, then an appended point
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, T_MASK, 1, 1)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 10, 0, -1)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 10, 0, 3)));
    tbl.insert(tbl.size(), plain(mk(MODE_TICK, 5, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, 0, 1, -3)));
    tbl.insert(tbl.size(), plain(mk(MODE_LOAD, 0, T_MASK, 0, 3)));
    tbl.insert(tbl.size(), plain(mk(MODE_TICK, T_MASK, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_PAUSE, 0, 0, 0, 0)));
    tbl.insert(tbl.size(), plain(mk(MODE_STOP, 0, 0, 0, 0)));

    foreach (tbl[i]) begin
      send_cmd(tbl[i].c);
      if (tbl[i].chk) begin
        n = pending_q.size();
        for (int k = n - NJ; k < n; k++) begin
          if (pending_q[k].pos !== tbl[i].epos || pending_q[k].vel !== tbl[i].evel ||
              pending_q[k].fin !== tbl[i].efin) begin
            errors++;
            $display("%0t: table row %0d exp p=%0d v=%0d f=%0b predictor p=%0d v=%0d f=%0b",
                     $realtime, i, tbl[i].epos, tbl[i].evel, tbl[i].efin,
                     pending_q[k].pos, pending_q[k].vel, pending_q[k].fin);
          end
          pending_q[k].pos = tbl[i].epos;
          pending_q[k].vel = tbl[i].evel;
          pending_q[k].fin = tbl[i].efin;
        end
      end
    end

    // table capacity: two points past the limit are dropped
    drain();
    write_scale(scales[0]);
    no_idle = 1;
    run_trajectory(NPTS + 2);
    no_idle = 0;

    base = items;
    for (int ph = 1; ph < 6; ph++) begin
      drain();
      write_scale(ph < 5 ? scales[ph] : SCALE_W'($urandom_range(26, 512)));
      while (items < base + (ITEMS_TARGET - base) * ph / 5) begin
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) begin
          c = rand_cmd(MODE_W'($urandom_range(0, 7)));
          send_cmd(c);
        end else begin
          n = $urandom_range(1, 6);
          run_trajectory(n);
        end
      end
    end
    no_idle = 0;
    drain();

    $display("covered %0d commands, %0d ticks, %0d waypoint loads, %0d result words checked",
             items, ticks, loads, checked);
    $display("speed scale written %0d times incl. 0, 26, 512 and 1023", cfg_writes);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0t: %0d errors, %0d expected words never arrived", $realtime, errors,
               pending_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
